[rtl/core/prc_pkg.sv]
// Shared types and constants for the partition label canonicalizer.
package prc_pkg;

  localparam int LABEL_FIELD_W = 16;  // width of original_label on the input stream
  localparam int COUNT_OUT_W   = 7;   // width of canonical_label and blocks_so_far
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new request into the working registers
    logic scan;     // step the table read pointer
    logic resolve;  // capture hit or miss and the matching index
    logic emit;     // write the result register and update the table
  } prc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the entry just read matches the label
    logic scan_end;  // the entry just read was the last valid one
    logic empty;     // the table holds no labels
    logic out_free;  // the result register can take a new result
  } prc_status_t;

endpackage

[rtl/core/prc_ctrl.sv]
// Controller state machine for the partition label canonicalizer.
module prc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prc_pkg::prc_status_t status,
  output prc_pkg::prc_cmd_t    cmd
);
  import prc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.resolve = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        // A match ends the search early; otherwise it runs to the last stored label.
        if (status.hit || status.empty || status.scan_end) begin
          cmd.resolve = 1'b1;
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/prc_dpath.sv]
// Datapath for the partition label canonicalizer: label table, search and result register.
module prc_dpath #(
  parameter int MAX_BLOCKS = 64,
  parameter int LABEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  prc_pkg::prc_cmd_t                     cmd,
  output prc_pkg::prc_status_t                  status,
  input  logic [prc_pkg::LABEL_FIELD_W-1:0]     in_label,
  input  logic                                  in_last,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [prc_pkg::COUNT_OUT_W-1:0]       out_label,
  output logic [prc_pkg::COUNT_OUT_W-1:0]       out_blocks,
  output logic                                  out_last,
  output logic                                  out_ovf
);
  import prc_pkg::*;

  localparam int LW = (LABEL_BITS < LABEL_FIELD_W) ? LABEL_BITS : LABEL_FIELD_W;
  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [LW-1:0] table_mem [MAX_BLOCKS];

  logic [LW-1:0] label;
  logic          last;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic          rd_valid;
  logic [AW-1:0] cmp_idx;
  logic [LW-1:0] rd_data;
  logic          res_hit;
  logic [AW-1:0] res_idx;

  logic          rd_en;
  logic          full;
  logic          append;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] rank_hit;

  assign rd_en     = cmd.scan && (rd_idx < count);
  assign full      = (count == CW'(MAX_BLOCKS));
  assign append    = !res_hit && !full;
  assign count_inc = count + CW'(1);
  assign rank_hit  = CW'(res_idx) + CW'(1);

  assign status.hit      = rd_valid && (rd_data == label);
  assign status.scan_end = rd_valid && ((CW'(cmp_idx) + CW'(1)) == count);
  assign status.empty    = (count == '0);
  assign status.out_free = !out_valid || out_ready;

  // Table storage: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= table_mem[rd_idx[AW-1:0]];
      cmp_idx <= rd_idx[AW-1:0];
    end
    if (cmd.emit && append) begin
      table_mem[count[AW-1:0]] <= label;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      label  <= in_label[LW-1:0];
      last   <= in_last;
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + CW'(1);
    end
    if (cmd.resolve) begin
      res_hit <= status.hit;
      res_idx <= cmp_idx;
    end
    if (cmd.emit) begin
      out_label  <= res_hit ? COUNT_OUT_W'(rank_hit)
                            : (full ? '0 : COUNT_OUT_W'(count_inc));
      out_blocks <= append ? COUNT_OUT_W'(count_inc) : COUNT_OUT_W'(count);
      out_last   <= last;
      out_ovf    <= !res_hit && full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en && !cmd.load;
      if (cmd.emit) begin
        if (last) begin
          count <= '0;
        end else if (append) begin
          count <= count_inc;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/partition_rgf_canonicalizer.sv]
// Top level of the partition label canonicalizer (restricted growth form relabeling).
//
//   channel  dir  tdata (low bit first)                           tlast          tuser
//   s_*      in   original_label[15:0]                            last_element   -
//   m_*      out  canonical_label[6:0], blocks_so_far[6:0], 0[1:0] last_out      overflow
//
// The search covers up to count stored labels, where count is the number of distinct labels
// stored for the current partition: the label table has one read port and the search
// reads one stored label per cycle, stopping at the first match.
// A new request is taken once the previous result sits in the output register.
// rst is synchronous and clears the block count; table contents are kept but unused.
// A stalled output holds the result and the controller waits before writing the next one.
module partition_rgf_canonicalizer #(
  parameter int MAX_BLOCKS = 64,
  parameter int LABEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [prc_pkg::IN_TDATA_W-1:0]   s_tdata,   // original_label
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [prc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // canonical_label, blocks_so_far
  output logic                             m_tlast,
  output logic                             m_tuser    // overflow
);
  import prc_pkg::*;

  prc_cmd_t    cmd;
  prc_status_t status;

  logic [COUNT_OUT_W-1:0] out_label;
  logic [COUNT_OUT_W-1:0] out_blocks;

  prc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  prc_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .LABEL_BITS (LABEL_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_label   (s_tdata[LABEL_FIELD_W-1:0]),
    .in_last    (s_tlast),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_label  (out_label),
    .out_blocks (out_blocks),
    .out_last   (m_tlast),
    .out_ovf    (m_tuser)
  );

  assign m_tdata = {{(OUT_TDATA_W - 2 * COUNT_OUT_W){1'b0}}, out_blocks, out_label};

endmodule
